// File: hw/rtl/atmma_pkg.sv
// ----------------------------------------------------------------------------
// atmma_pkg
// Shared constants and types of the ADC trimmed-mean moving-average block.
// ----------------------------------------------------------------------------
`default_nettype none

package atmma_pkg;

  localparam int unsigned MaxChannels  = 16;
  localparam int unsigned MaxSamples   = 256;
  localparam int unsigned MaxWindow    = 64;
  localparam int unsigned TrimMinCount = 2;

  localparam int unsigned ChanW     = $clog2(MaxChannels);
  localparam int unsigned SeqW      = $clog2(MaxSamples);
  localparam int unsigned SlotW     = $clog2(MaxWindow);
  localparam int unsigned HistDepth = MaxChannels * MaxWindow;
  localparam int unsigned HistAddrW = $clog2(HistDepth);

  localparam int unsigned SampleW  = 16;
  localparam int unsigned SumW     = 24;
  localparam int unsigned WsumW    = 22;
  localparam int unsigned AvgW     = 24;
  localparam int unsigned FracW    = 8;
  localparam int unsigned CcW      = 5;
  localparam int unsigned SpcW     = 9;
  localparam int unsigned WlW      = 7;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DivNumW = 32;
  localparam int unsigned DivDenW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_COUNT       = 4'd0,
    CFG_SAMPLES_PER_CHANNEL = 4'd1,
    CFG_WINDOW_LENGTH       = 4'd2,
    CFG_DROP_EXTREMES       = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/atmma_div.sv
// ----------------------------------------------------------------------------
// atmma_div
// Restoring divider, one quotient bit per cycle, pulses done with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module atmma_div
  import atmma_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned IterW = $clog2(DivNumW);

  logic               busy_q;
  logic               done_q;
  logic [IterW-1:0]   cnt_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;

  logic [DivDenW:0]   trial;
  logic               ge;
  logic [DivDenW:0]   diff;
  logic [DivDenW-1:0] rem_d;

  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  assign rem_d = ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == IterW'(DivNumW - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + IterW'(1);
        if (cnt_q == IterW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivNumW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/adc_trimmed_mean_moving_average_top.sv
// ----------------------------------------------------------------------------
// adc_trimmed_mean_moving_average_top
// Per-channel burst mean with optional min/max trim and a moving window.
// ----------------------------------------------------------------------------
// After reset the block sweeps its history memory and holds in_stall_o high;
// configuration writes are taken during that sweep. A sample that is not the
// last of its channel's burst is read from the per-channel stage memory, then
// modified and written back. For a channel's final sample both the mean and
// the window average run through one shared divider that retires one quotient
// bit per cycle. A result waits in an output register: samples keep being
// taken while it is stalled, and a further final sample holds at the emit step
// until that register frees.
`default_nettype none

module adc_trimmed_mean_moving_average_top
  import atmma_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [SampleW-1:0]  sample_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ChanW-1:0]         channel_o,
  output logic [SampleW-1:0]       raw_mean_o,
  output logic [AvgW-1:0]          moving_average_o,
  output logic [WlW-1:0]           filled_count_o,
  output logic                     last_channel_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MEAN_WAIT,
    ST_AVG_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [SumW-1:0]    sum;
    logic [SampleW-1:0] min;
    logic [SampleW-1:0] max;
    logic [WsumW-1:0]   wsum;
  } chan_word_t;

  // configuration
  logic [CcW-1:0]  cc_q;
  logic [SpcW-1:0] spc_q;
  logic [WlW-1:0]  wl_q;
  logic            drop_q;
  logic            cfg_fire;
  logic            cfg_restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= CcW'(1);
      spc_q  <= SpcW'(1);
      wl_q   <= WlW'(1);
      drop_q <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHANNEL_COUNT:       cc_q   <= cfg_data_i[CcW-1:0];
        CFG_SAMPLES_PER_CHANNEL: spc_q  <= cfg_data_i[SpcW-1:0];
        CFG_WINDOW_LENGTH:       wl_q   <= cfg_data_i[WlW-1:0];
        CFG_DROP_EXTREMES:       drop_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHANNEL_COUNT, CFG_SAMPLES_PER_CHANNEL: cfg_restart = 1'b1;
        default: cfg_restart = 1'b0;
      endcase
    end
  end

  logic [CcW-1:0]  cc_eff;
  logic [SpcW-1:0] spc_eff;
  logic [WlW-1:0]  wl_eff;

  always_comb begin
    if (cc_q == '0) cc_eff = CcW'(1);
    else if (cc_q > CcW'(MaxChannels)) cc_eff = CcW'(MaxChannels);
    else cc_eff = cc_q;
    if (spc_q == '0) spc_eff = SpcW'(1);
    else if (spc_q > SpcW'(MaxSamples)) spc_eff = SpcW'(MaxSamples);
    else spc_eff = spc_q;
    if (wl_q == '0) wl_eff = WlW'(1);
    else if (wl_q > WlW'(MaxWindow)) wl_eff = WlW'(MaxWindow);
    else wl_eff = wl_q;
  end

  // control state
  state_e              state_q;
  logic [HistAddrW-1:0] clr_q;
  logic [ChanW-1:0]    ch_q;
  logic [SeqW-1:0]     seq_q;
  logic [SlotW-1:0]    wslot_q;
  logic                full_q;

  logic                 out_valid_q;
  logic [ChanW-1:0]     out_chan_q;
  logic [SampleW-1:0]   out_mean_q;
  logic [AvgW-1:0]      out_avg_q;
  logic [WlW-1:0]       out_filled_q;
  logic                 out_last_q;

  // item datapath registers
  logic [SampleW-1:0] s_q;
  logic [SampleW-1:0] mean_q;
  logic [AvgW-1:0]    avg_q;

  // memories
  chan_word_t           chan_mem [MaxChannels];
  chan_word_t           chan_rd_q;
  logic                 chan_we;
  logic [ChanW-1:0]     chan_waddr;
  chan_word_t           chan_wdata;

  logic [SampleW-1:0]   hist_mem [HistDepth];
  logic [SampleW-1:0]   hist_rd_q;
  logic                 hist_we;
  logic [HistAddrW-1:0] hist_waddr;
  logic [SampleW-1:0]   hist_wdata;

  logic                 in_fire;
  logic                 out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // position bookkeeping
  logic [CcW-1:0]   ch_inc;
  logic [SpcW-1:0]  seq_inc;
  logic             ch_wrap;
  logic             seq_wrap;
  logic             is_last;
  logic             is_final;
  logic             slot_wrap;
  logic [SlotW-1:0] slot_eff;
  logic             full_eff;
  logic [WlW-1:0]   slot_inc;
  logic [WlW-1:0]   filled;
  logic             pos_adv;

  assign ch_inc    = {1'b0, ch_q} + CcW'(1);
  assign seq_inc   = {1'b0, seq_q} + SpcW'(1);
  assign ch_wrap   = ch_inc >= cc_eff;
  assign seq_wrap  = seq_inc >= spc_eff;
  assign is_last   = ({1'b0, ch_q} == cc_eff - CcW'(1));
  assign is_final  = ({1'b0, seq_q} == spc_eff - SpcW'(1));
  assign slot_wrap = {1'b0, wslot_q} >= wl_eff;
  assign slot_eff  = slot_wrap ? '0 : wslot_q;
  assign full_eff  = full_q || slot_wrap;
  assign slot_inc  = {1'b0, slot_eff} + WlW'(1);
  assign filled    = full_eff ? wl_eff : slot_inc;
  assign pos_adv   = (state_q == ST_READ && !is_final) || (state_q == ST_EMIT && out_free);

  // stage update
  logic [SumW-1:0]    sum_n;
  logic [SampleW-1:0] min_n;
  logic [SampleW-1:0] max_n;
  logic               trim;
  logic [SumW-1:0]    sum_trim;
  logic [SpcW-1:0]    n_eff;
  logic [DivNumW-1:0] mean_num;
  logic [SampleW-1:0] mean_sat;
  logic [WsumW-1:0]   wsum_new;
  logic [AvgW-1:0]    avg_sat;

  always_comb begin
    if (seq_q == '0) begin
      sum_n = SumW'(s_q);
      min_n = s_q;
      max_n = s_q;
    end else begin
      sum_n = chan_rd_q.sum + SumW'(s_q);
      min_n = (s_q < chan_rd_q.min) ? s_q : chan_rd_q.min;
      max_n = (s_q > chan_rd_q.max) ? s_q : chan_rd_q.max;
    end
    trim     = drop_q && (spc_eff > SpcW'(TrimMinCount));
    sum_trim = trim ? (sum_n - SumW'(min_n) - SumW'(max_n)) : sum_n;
    n_eff    = trim ? (spc_eff - SpcW'(TrimMinCount)) : spc_eff;
    mean_num = DivNumW'({sum_trim, 1'b0}) + DivNumW'(n_eff);
    mean_sat = (div_rsp.quo > DivNumW'({SampleW{1'b1}})) ? {SampleW{1'b1}}
             : div_rsp.quo[SampleW-1:0];
    wsum_new = chan_rd_q.wsum - WsumW'(hist_rd_q) + WsumW'(mean_sat);
    avg_sat  = (div_rsp.quo[DivNumW-1:AvgW] != '0) ? {AvgW{1'b1}}
             : div_rsp.quo[AvgW-1:0];
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = mean_num;
    div_req.den   = DivDenW'({n_eff, 1'b0});
    if (state_q == ST_READ && is_final) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_MEAN_WAIT) begin
      div_req.start = div_rsp.done;
      div_req.num   = DivNumW'({wsum_new, {FracW{1'b0}}});
      div_req.den   = DivDenW'(filled);
    end
  end

  atmma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // memory write ports
  always_comb begin
    chan_we         = 1'b0;
    chan_waddr      = ch_q;
    chan_wdata.sum  = sum_n;
    chan_wdata.min  = min_n;
    chan_wdata.max  = max_n;
    chan_wdata.wsum = chan_rd_q.wsum;
    hist_we         = 1'b0;
    hist_waddr      = {ch_q, slot_eff};
    hist_wdata      = mean_sat;
    case (state_q)
      ST_CLEAR: begin
        chan_we         = clr_q < HistAddrW'(MaxChannels);
        chan_waddr      = clr_q[ChanW-1:0];
        chan_wdata.sum  = '0;
        chan_wdata.min  = '1;
        chan_wdata.max  = '0;
        chan_wdata.wsum = '0;
        hist_we         = 1'b1;
        hist_waddr      = clr_q;
        hist_wdata      = '0;
      end
      ST_READ: begin
        chan_we = !is_final;
      end
      ST_MEAN_WAIT: begin
        chan_we         = div_rsp.done;
        chan_wdata.sum  = '0;
        chan_wdata.min  = '1;
        chan_wdata.max  = '0;
        chan_wdata.wsum = wsum_new;
        hist_we         = div_rsp.done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (chan_we) begin
      chan_mem[chan_waddr] <= chan_wdata;
    end
    if (in_fire) begin
      chan_rd_q <= chan_mem[ch_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (in_fire) begin
      hist_rd_q <= hist_mem[{ch_q, slot_eff}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_q <= sample_i;
    end
    if (state_q == ST_MEAN_WAIT && div_rsp.done) begin
      mean_q <= mean_sat;
    end
    if (state_q == ST_AVG_WAIT && div_rsp.done) begin
      avg_q <= avg_sat;
    end
  end

  // scan position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      seq_q <= '0;
    end else if (cfg_restart) begin
      ch_q  <= '0;
      seq_q <= '0;
    end else if (pos_adv) begin
      ch_q <= ch_wrap ? '0 : ch_inc[ChanW-1:0];
      if (ch_wrap) begin
        seq_q <= seq_wrap ? '0 : seq_inc[SeqW-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      wslot_q      <= '0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_chan_q   <= '0;
      out_mean_q   <= '0;
      out_avg_q    <= '0;
      out_filled_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + HistAddrW'(1);
          if (&clr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (is_final) begin
            state_q <= ST_MEAN_WAIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            state_q <= ST_AVG_WAIT;
          end
        end
        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_chan_q   <= ch_q;
            out_mean_q   <= mean_q;
            out_avg_q    <= avg_q;
            out_filled_q <= filled;
            out_last_q   <= is_last;
            if (is_last) begin
              if (slot_inc >= wl_eff) begin
                wslot_q <= '0;
                full_q  <= 1'b1;
              end else begin
                wslot_q <= slot_inc[SlotW-1:0];
                full_q  <= full_eff;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_o        = out_chan_q;
  assign raw_mean_o       = out_mean_q;
  assign moving_average_o = out_avg_q;
  assign filled_count_o   = out_filled_q;
  assign last_channel_o   = out_last_q;

`ifndef ASSERT_OFF
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_MEAN_WAIT || state_q == ST_AVG_WAIT))
    else $error("divider finished with no one waiting");

  a_filled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (filled_count_o != '0 && filled_count_o <= WlW'(MaxWindow)))
    else $error("filled count out of range");
`endif

endmodule

`default_nettype wire
